[hdl/assert_macros.svh]
// Assertion macros used by the command frame checker parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[hdl/cfc_pkg.sv]
// Types and constants of the command frame checker.
`timescale 1ns / 1ps
package cfc_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumCap   = 5;

  localparam logic [7:0] DelimReset  = 8'd126;
  localparam logic [5:0] SwOpReset   = 6'd16;
  localparam logic [7:0] ChkBase     = 8'hFF;
  localparam logic [7:0] SysCmdMin   = 8'h01;
  localparam logic [7:0] SysCmdMax   = 8'h0F;
  localparam logic [7:0] AppCmdMin   = 8'h10;
  localparam logic [7:0] AppCmdMax   = 8'h20;

  typedef enum logic {
    REG_DELIM = 1'b0,
    REG_SWOP  = 1'b1
  } cfc_reg_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LEN     = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } cfc_phase_e;

  typedef enum logic [2:0] {
    ST_SYS_CMD   = 3'd0,
    ST_SW_CMD    = 3'd1,
    ST_APP_UNH   = 3'd2,
    ST_INVALID   = 3'd3,
    ST_BAD_DELIM = 3'd4,
    ST_BAD_CSUM  = 3'd5
  } cfc_status_e;

  typedef struct packed {
    logic [7:0] delim;
    logic [5:0] sw_op;
  } cfc_cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } cfc_item_t;

  typedef struct packed {
    cfc_status_e status;
    logic [7:0]  command;
    logic [7:0]  command_type;
    logic [7:0]  switch_number;
    logic [7:0]  request_kind;
    logic [7:0]  switch_state;
  } cfc_result_t;

endpackage

[hdl/cfc_if.sv]
// Valid/ready channel interfaces for frame bytes and check results.
`timescale 1ns / 1ps
interface cfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;

  modport source (output valid, frame_byte, frame_start, input ready);
  modport sink   (input valid, frame_byte, frame_start, output ready);
endinterface

interface cfc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] command;
  logic [7:0] command_type;
  logic [7:0] switch_number;
  logic [7:0] request_kind;
  logic [7:0] switch_state;

  modport source (output valid, status, command, command_type, switch_number,
                  request_kind, switch_state, input ready);
  modport sink   (input valid, status, command, command_type, switch_number,
                  request_kind, switch_state, output ready);
endinterface

[hdl/cfc_regs.sv]
// APB configuration registers: start delimiter and switch opcode.
`timescale 1ns / 1ps
module cfc_regs
  import cfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfc_cfg_t            cfg_o
);

  logic [7:0] delim_q, delim_d;
  logic [5:0] sw_op_q, sw_op_d;
  logic       wr_en;
  cfc_reg_e   reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfc_reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    delim_d = delim_q;
    sw_op_d = sw_op_q;
    prdata  = '0;
    case (reg_sel)
      REG_DELIM: begin
        prdata = {{(CfgDataW-8){1'b0}}, delim_q};
        if (wr_en) delim_d = pwdata[7:0];
      end
      REG_SWOP: begin
        prdata = {{(CfgDataW-6){1'b0}}, sw_op_q};
        if (wr_en) sw_op_d = pwdata[5:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DelimReset;
      sw_op_q <= SwOpReset;
    end else begin
      delim_q <= delim_d;
      sw_op_q <= sw_op_d;
    end
  end

  assign cfg_o = '{delim: delim_q, sw_op: sw_op_q};

endmodule

[hdl/cfc_in_reg.sv]
// Input register for incoming frame words.
`timescale 1ns / 1ps
module cfc_in_reg
  import cfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  cfc_in_if.sink    in_i,
  input  logic      adv_i,
  output logic      vld_o,
  output cfc_item_t item_o
);

  logic      vld_q, vld_d;
  cfc_item_t item_q;
  logic      take;

  // a word leaves the register in the same cycle a new one lands
  assign in_i.ready = !vld_q || adv_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (take) vld_d = 1'b1;
    else if (adv_i) vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else vld_q <= vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= '{frame_byte: in_i.frame_byte, frame_start: in_i.frame_start};
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

[hdl/cfc_parser.sv]
// Frame parser: phase tracking, checksum, capture and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cfc_parser
  import cfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfc_cfg_t  cfg_i,
  input  logic      vld_i,
  input  cfc_item_t item_i,
  output logic      adv_o,
  cfc_out_if.source out_o
);

  cfc_phase_e            phase_q, phase_d;
  logic [7:0]            len_q, len_d;
  logic [7:0]            pos_q, pos_d;
  logic [7:0]            sum_q, sum_d;
  logic [NumCap-1:0][7:0] cap_q, cap_d;
  logic                  out_vld_q, out_vld_d;
  cfc_result_t           res_q, res_d;
  logic                  res_vld;
  logic [7:0]            pos_inc;
  logic [7:0]            csum_exp;
  logic [7:0]            cmd;
  logic [7:0]            b;

  assign adv_o    = vld_i && (!out_vld_q || out_o.ready);
  assign b        = item_i.frame_byte;
  assign pos_inc  = pos_q + 8'd1;
  assign csum_exp = ChkBase - sum_q;
  assign cmd      = cap_q[0];

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    pos_d   = pos_q;
    sum_d   = sum_q;
    cap_d   = cap_q;
    res_vld = 1'b0;
    res_d   = '0;
    if (adv_o) begin
      if (item_i.frame_start) begin
        cap_d = '0;
        len_d = '0;
        pos_d = '0;
        sum_d = '0;
        if (b != cfg_i.delim) begin
          phase_d      = PH_IDLE;
          res_vld      = 1'b1;
          res_d.status = ST_BAD_DELIM;
        end else begin
          phase_d = PH_LEN;
        end
      end else begin
        case (phase_q)
          PH_LEN: begin
            len_d   = b;
            pos_d   = '0;
            sum_d   = '0;
            phase_d = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            sum_d = sum_q + b;
            if (pos_q < 8'(NumCap)) cap_d[pos_q[2:0]] = b;
            pos_d = pos_inc;
            if (pos_inc == len_q) phase_d = PH_CHECK;
          end
          PH_CHECK: begin
            phase_d = PH_IDLE;
            res_vld = 1'b1;
            if (csum_exp != b) begin
              res_d.status = ST_BAD_CSUM;
            end else begin
              res_d.command = cmd;
              if (cmd >= SysCmdMin && cmd <= SysCmdMax) begin
                res_d.status = ST_SYS_CMD;
              end else if (cmd >= AppCmdMin && cmd <= AppCmdMax) begin
                if (cmd == {2'b00, cfg_i.sw_op}) begin
                  res_d.status        = ST_SW_CMD;
                  res_d.command_type  = cap_q[1];
                  res_d.switch_number = cap_q[2];
                  res_d.request_kind  = cap_q[3];
                  res_d.switch_state  = cap_q[4];
                end else begin
                  res_d.status = ST_APP_UNH;
                end
              end else begin
                res_d.status = ST_INVALID;
              end
            end
          end
          PH_IDLE: phase_d = PH_IDLE;  // stray word outside a frame
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q && !out_o.ready;
    if (adv_o) out_vld_d = res_vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      len_q     <= '0;
      pos_q     <= '0;
      sum_q     <= '0;
      cap_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      cap_q     <= cap_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_vld) res_q <= res_d;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = res_q.status;
  assign out_o.command       = res_q.command;
  assign out_o.command_type  = res_q.command_type;
  assign out_o.switch_number = res_q.switch_number;
  assign out_o.request_kind  = res_q.request_kind;
  assign out_o.switch_state  = res_q.switch_state;

  `ASSERT_PROP(a_err_fields_zero, clk_i, rst_ni,
    out_vld_q && (res_q.status == ST_BAD_DELIM || res_q.status == ST_BAD_CSUM)
      |-> res_q.command == 8'd0 && res_q.switch_state == 8'd0,
    "error result carries payload bytes")
  `ASSERT_PROP(a_nonsw_fields_zero, clk_i, rst_ni,
    out_vld_q && res_q.status != ST_SW_CMD
      |-> res_q.command_type == 8'd0 && res_q.request_kind == 8'd0,
    "non-switch result carries switch bytes")
  `ASSERT_PROP(a_good_delim_len, clk_i, rst_ni,
    adv_o && item_i.frame_start && b == cfg_i.delim |=> phase_q == PH_LEN,
    "matching delimiter did not open a frame")
  `ASSERT_NEVER(a_pos_in_range, clk_i, rst_ni,
    phase_q == PH_PAYLOAD && pos_q >= len_q,
    "payload position ran past length")
  `ASSERT_NEVER(a_adv_while_stalled, clk_i, rst_ni,
    adv_o && out_vld_q && !out_o.ready,
    "word consumed while result stalled")

endmodule

[hdl/command_frame_checker_unit.sv]
// Top level of the command frame checker.
`timescale 1ns / 1ps
// Command frame checker: parses frames of the form
//   delimiter, length L, L payload bytes, checksum (0xFF minus payload sum).
// in_i carries one frame byte per word; frame_start marks a frame's first
// byte and always drops any partial frame without a result.
// out_o carries one word per completed or rejected frame: a status code
// (system, switch, unhandled app, invalid, bad delimiter, bad checksum) and
// the first five payload bytes where the status calls for them.
// The APB port holds the start delimiter (address 0) and the switch opcode
// (address 4); write them only while no frame is in flight.
// Throughput: one input word per cycle while out_o takes results; the parse
// step sits between the input register and the result register.
// A result is registered once its checksum byte leaves the input register.
// When out_o stalls, the result register holds and one further word may sit
// in the input register; in_i.ready then drops until the result is taken.
// Reset clears the parser to idle, drops pending words and loads the
// register defaults (delimiter 0x7E, switch opcode 16).
module command_frame_checker_unit
  import cfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  cfc_in_if.sink              in_i,
  cfc_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfc_cfg_t  cfg;
  logic      stage_vld;
  cfc_item_t stage_item;
  logic      adv;

  cfc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cfc_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .adv_i  (adv),
    .vld_o  (stage_vld),
    .item_o (stage_item)
  );

  cfc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .vld_i  (stage_vld),
    .item_i (stage_item),
    .adv_o  (adv),
    .out_o  (out_o)
  );

endmodule

[tb/sv/cfc_verdict_checker.sv]
// Scoreboard for the command frame checker: predicts frame verdicts and compares them.
`timescale 1ns / 1ps
module cfc_verdict_checker
  import cfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  cfc_in_if                   in_i,
  cfc_out_if                  out_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  input  logic                pready,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int MaxPrinted = 50;

  // shadow copy of the parser
  cfc_phase_e  phase_q;
  logic [7:0]  len_q;
  logic [7:0]  pos_q;
  logic [7:0]  sum_q;
  logic [7:0]  cap_q [NumCap];
  logic [7:0]  delim_q;
  logic [5:0]  swop_q;

  cfc_result_t verdict_q [$];
  cfc_result_t got;
  cfc_result_t want;
  cfc_result_t fresh;

  task automatic report_mismatch(input string what);
    if (fail_cnt_o < MaxPrinted) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
    fail_cnt_o++;
  endtask

  task automatic check_field(input string name, input logic [7:0] seen, input logic [7:0] exp);
    if (seen !== exp) begin
      report_mismatch($sformatf("verdict %0d %s got %02h exp %02h", checked_o, name, seen, exp));
    end
  endtask

  // Advance the shadow parser by one word; returns 1 when the word yields a verdict.
  function automatic bit parse_word(input logic [7:0] b, input logic start,
                                    output cfc_result_t r);
    int         i;
    logic [7:0] csum;
    logic [7:0] cmd;
    r = '0;
    if (start) begin
      for (i = 0; i < NumCap; i++) cap_q[i] = '0;
      len_q = '0;
      pos_q = '0;
      sum_q = '0;
      if (b != delim_q) begin
        phase_q  = PH_IDLE;
        r.status = ST_BAD_DELIM;
        return 1'b1;
      end
      phase_q = PH_LEN;
      return 1'b0;
    end
    case (phase_q)
      PH_LEN: begin
        len_q   = b;
        pos_q   = '0;
        sum_q   = '0;
        phase_q = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_q = sum_q + b;
        if (pos_q < NumCap) cap_q[pos_q] = b;
        pos_q = pos_q + 8'd1;
        if (pos_q == len_q) phase_q = PH_CHECK;
      end
      PH_CHECK: begin
        phase_q = PH_IDLE;
        csum    = 8'hFF - sum_q;
        if (csum != b) begin
          r.status = ST_BAD_CSUM;
          return 1'b1;
        end
        cmd       = cap_q[0];
        r.command = cmd;
        if (cmd >= 8'h01 && cmd <= 8'h0F) begin
          r.status = ST_SYS_CMD;
        end else if (cmd >= 8'h10 && cmd <= 8'h20) begin
          if (cmd == {2'b00, swop_q}) begin
            r.status        = ST_SW_CMD;
            r.command_type  = cap_q[1];
            r.switch_number = cap_q[2];
            r.request_kind  = cap_q[3];
            r.switch_state  = cap_q[4];
          end else begin
            r.status = ST_APP_UNH;
          end
        end else begin
          r.status = ST_INVALID;
        end
        return 1'b1;
      end
      default: phase_q = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q = PH_IDLE;
      len_q   = '0;
      pos_q   = '0;
      sum_q   = '0;
      for (int i = 0; i < NumCap; i++) cap_q[i] = '0;
      delim_q = DelimReset;
      swop_q  = SwOpReset;
      verdict_q.delete();
      fail_cnt_o = 0;
      checked_o  = 0;
      pending_o  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == CfgAddrW'(int'(REG_DELIM) * 4)) delim_q = pwdata[7:0];
        else if (paddr == CfgAddrW'(int'(REG_SWOP) * 4)) swop_q = pwdata[5:0];
      end
      // output side first: a verdict can never leave in the cycle its word enters
      if (out_i.valid && out_i.ready) begin
        got.status        = cfc_status_e'(out_i.status);
        got.command       = out_i.command;
        got.command_type  = out_i.command_type;
        got.switch_number = out_i.switch_number;
        got.request_kind  = out_i.request_kind;
        got.switch_state  = out_i.switch_state;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected verdict, status %0d cmd %02h",
                                    out_i.status, out_i.command));
        end else begin
          want = verdict_q.pop_front();
          check_field("status", {5'b0, out_i.status}, {5'b0, want.status});
          check_field("command", got.command, want.command);
          check_field("command_type", got.command_type, want.command_type);
          check_field("switch_number", got.switch_number, want.switch_number);
          check_field("request_kind", got.request_kind, want.request_kind);
          check_field("switch_state", got.switch_state, want.switch_state);
          checked_o++;
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (parse_word(in_i.frame_byte, in_i.frame_start, fresh)) verdict_q.push_back(fresh);
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

[tb/sv/command_frame_checker_unit_test.sv]
// Testbench top for the command frame checker: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module command_frame_checker_unit_test;
  import cfc_pkg::*;

  localparam int    ClkPeriod   = 10;
  localparam int    NumPhases   = 6;
  localparam int    PhaseWords  = 250;
  localparam int    HoldCycles  = 300;
  localparam int    SettleCycles = 8;
  localparam time   RunLimit    = 1ms;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  int fail_count;
  int pending;
  int checked;

  cfc_in_if  in_if ();
  cfc_out_if out_if ();

  // stimulus state
  cfc_item_t  word_q [$];
  logic [7:0] delim_cur;
  logic [5:0] swop_cur;
  int         send_idle;
  int         recv_stall;
  int         hold_left;
  int         words_sent;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  command_frame_checker_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  cfc_verdict_checker verdict_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_i     (out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .fail_cnt_o(fail_count),
    .pending_o (pending),
    .checked_o (checked)
  );

  function automatic void add_word(input logic [7:0] b, input logic start);
    cfc_item_t w;
    w.frame_byte  = b;
    w.frame_start = start;
    word_q.push_back(w);
  endfunction

  // delimiter, length, payload led by cmd, checksum (right or corrupted)
  function automatic void add_frame(input logic [7:0] len, input logic [7:0] cmd, input bit good);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    add_word(delim_cur, 1'b1);
    add_word(len, 1'b0);
    sum = '0;
    for (i = 0; i < int'(len); i++) begin
      b   = (i == 0) ? cmd : 8'($urandom);
      sum = sum + b;
      add_word(b, 1'b0);
    end
    b = 8'hFF - sum;
    if (!good) b = b ^ 8'($urandom_range(255, 1));
    add_word(b, 1'b0);
  endfunction

  // Mostly well-formed frames; the rest is bad delimiters, strays and cut-off frames.
  // Every choice leaves the parser idle at its end.
  function automatic void add_random_frame();
    int         kind;
    int         k;
    int         cut;
    logic [7:0] len;
    logic [7:0] cmd;
    logic [7:0] b;
    kind = $urandom_range(99);
    k    = $urandom_range(99);
    if (k < 88) len = 8'($urandom_range(7));
    else if (k < 98) len = 8'($urandom_range(40, 8));
    else len = 8'($urandom_range(255, 200));
    case ($urandom_range(4))
      0: cmd = 8'($urandom_range(15, 1));
      1: cmd = {2'b00, swop_cur};
      2: cmd = 8'($urandom_range(32, 16));
      3: cmd = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255, 33));
      default: cmd = 8'($urandom);
    endcase
    if (kind < 65) begin
      add_frame(len, cmd, $urandom_range(99) < 85);
    end else if (kind < 75) begin
      b = 8'($urandom);
      if (b == delim_cur) b = b + 8'd1;
      add_word(b, 1'b1);
    end else if (kind < 83) begin
      cut = $urandom_range(3, 1);
      for (k = 0; k < cut; k++) add_word(8'($urandom), 1'b0);
    end else begin
      // frame dropped part way by a new start
      add_word(delim_cur, 1'b1);
      cut = $urandom_range(int'(len) + 1);
      for (k = 0; k < cut; k++) add_word((k == 0) ? len : 8'($urandom), 1'b0);
      if ($urandom_range(1) == 1) begin
        b = 8'($urandom);
        if (b == delim_cur) b = b + 8'd1;
        add_word(b, 1'b1);
      end
      add_frame(8'($urandom_range(6)), cmd, 1'b1);
    end
  endfunction

  // Called at a rising edge; returns at a rising edge with valid low.
  task automatic send_words();
    cfc_item_t w;
    bit        rdy;
    while (word_q.size() > 0) begin
      w = word_q.pop_front();
      while ($urandom_range(99) < send_idle) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      in_if.valid       <= 1'b1;
      in_if.frame_byte  <= w.frame_byte;
      in_if.frame_start <= w.frame_start;
      // ready is stable from the falling edge to the next rising edge
      do begin
        @(negedge clk_i);
        rdy = in_if.ready;
        @(posedge clk_i);
      end while (!rdy);
      words_sent++;
    end
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_write(input cfc_reg_e r, input logic [CfgDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'(int'(r) * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every expected verdict, then let trailing words settle
  task automatic drain();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  initial begin
    #(RunLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int ph;
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_if.valid       <= 1'b0;
    in_if.frame_byte  <= '0;
    in_if.frame_start <= 1'b0;
    send_idle  = 0;
    recv_stall = 0;
    hold_left  = 0;
    words_sent = 0;
    delim_cur  = DelimReset;
    swop_cur   = SwOpReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 80; recv_stall = 0;  delim_cur = 8'h00; swop_cur = 6'd32; end
        2: begin send_idle = 0;  recv_stall = 80; delim_cur = 8'hFF; swop_cur = 6'h3F; end
        3: begin
          send_idle = 22; recv_stall = 22;
          delim_cur = 8'($urandom);
          swop_cur  = 6'($urandom_range(32, 16));
        end
        4: begin send_idle = 0;  recv_stall = 0;  delim_cur = 8'h7E; swop_cur = 6'd0; end
        default: begin
          send_idle = 22; recv_stall = 22;
          delim_cur = 8'($urandom);
          swop_cur  = 6'd16;
        end
      endcase
      if (ph != 0) begin
        apb_write(REG_DELIM, {24'd0, delim_cur});
        apb_write(REG_SWOP, {26'd0, swop_cur});
      end

      if (ph == 0) begin
        add_frame(8'd0, 8'h00, 1'b1);     // empty payload
        add_word(8'h5A, 1'b0);            // stray byte while idle
        add_word(8'h00, 1'b1);            // bad delimiters
        add_word(8'hFF, 1'b1);
        add_frame(8'd1, 8'h01, 1'b1);     // system command
        add_frame(8'd5, 8'h10, 1'b1);     // switch control, all five bytes
        add_frame(8'd1, 8'h0F, 1'b0);     // bad checksum
        add_word(delim_cur, 1'b1);        // partial frame dropped by restart
        add_word(8'd3, 1'b0);
        add_word(8'h20, 1'b0);
        add_frame(8'd1, 8'h20, 1'b1);     // unhandled application command
      end

      if (ph == 4) begin
        // long result back-pressure while the sender keeps offering bad delimiters
        hold_left = HoldCycles;
        repeat (40) add_word(8'h00, 1'b1);
      end

      while (word_q.size() < PhaseWords) add_random_frame();
      send_words();
      drain();
    end

    $display("Covered %0d frame words over %0d delimiter/opcode settings and idle mixes,",
             words_sent, NumPhases);
    $display("including a long output hold-off; %0d verdicts compared, %0d mismatches.",
             checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
